### hw/rtl/pcds_pkg.sv
package pcds_pkg;

  localparam int BANDS  = 16;
  localparam int BAND_W = $clog2(BANDS);

  // Signed width of (mean - z_minimum), and of that difference times BANDS.
  localparam int DW = 34;
  localparam int NW = DW + BAND_W + 1;

  // ceil(2^35 / 3): exact floor(x / 3) for every x below 2^35.
  localparam logic [33:0] RECIP3 = 34'd11453246123;
  localparam int RECIP_SHIFT = 35;

  localparam logic [1:0] CFG_Z_MINIMUM    = 2'd0;
  localparam logic [1:0] CFG_Z_SPAN       = 2'd1;
  localparam logic [1:0] CFG_FORCE_ENABLE = 2'd2;
  localparam logic [1:0] CFG_FORCED_COLOR = 2'd3;

  typedef struct packed {
    logic       vis;
    logic [7:0] color;
  } side_t;

endpackage

### hw/rtl/pcds_front.sv
module pcds_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        accept,
  input  logic        mode,
  input  logic [31:0] camera_dot,
  input  logic [31:0] plane_distance,
  input  logic [31:0] vertex_z_a,
  input  logic [31:0] vertex_z_b,
  input  logic [31:0] vertex_z_c,
  input  logic [31:0] light_dot,
  input  logic [7:0]  palette_slot,
  input  logic [7:0]  palette_value,
  output logic        v1,
  output logic        vis1,
  output logic        sign1,
  output logic [32:0] mag1,
  output logic [7:0]  pal1
);

  logic [7:0]  palette [0:255];
  logic [32:0] above;
  logic [33:0] sum;
  logic [33:0] sum_abs;
  logic [7:0]  shade_index;

  always_comb begin
    above = {camera_dot[31], camera_dot} - {plane_distance[31], plane_distance};
    sum = {{2{vertex_z_a[31]}}, vertex_z_a} + {{2{vertex_z_b[31]}}, vertex_z_b}
        + {{2{vertex_z_c[31]}}, vertex_z_c};
    sum_abs = sum[33] ? (34'd0 - sum) : sum;
    if (light_dot[31]) begin
      shade_index = 8'd0;
    end else if (light_dot[30:14] != 17'd0) begin
      shade_index = 8'hFF;
    end else begin
      shade_index = light_dot[13:6];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode) begin
      palette[palette_slot] <= palette_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept && !mode;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis1  <= !above[32] && (above != 33'd0);
      sign1 <= sum[33];
      mag1  <= sum_abs[32:0];
      pal1  <= palette[shade_index];
    end
  end

endmodule

### hw/rtl/pcds_mean.sv
module pcds_mean (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      v1,
  input  logic                      vis1,
  input  logic                      sign1,
  input  logic [32:0]               mag1,
  input  logic [7:0]                pal1,
  input  logic [31:0]               z_minimum,
  input  logic                      force_color_enable,
  input  logic [7:0]                forced_color,
  output logic                      v4,
  output pcds_pkg::side_t           side4,
  output logic [pcds_pkg::NW-1:0]   n4
);

  logic            v2, v3;
  pcds_pkg::side_t side2, side3;
  logic            sign2, sign3;
  logic [50:0]     plo;
  logic [49:0]     phi;
  logic [31:0]     q3;
  logic [66:0]     prod;
  logic [pcds_pkg::DW-1:0] mean;
  logic [pcds_pkg::DW-1:0] diff;

  always_comb begin
    prod = {phi, 17'd0} + {16'd0, plo};
    mean = sign3 ? (pcds_pkg::DW'(0) - {2'b00, q3}) : {2'b00, q3};
    diff = mean - {{(pcds_pkg::DW - 32){z_minimum[31]}}, z_minimum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The 33-bit magnitude is split so each partial product stays narrow.
      plo         <= mag1[16:0] * pcds_pkg::RECIP3;
      phi         <= mag1[32:17] * pcds_pkg::RECIP3;
      sign2       <= sign1;
      side2.vis   <= vis1;
      side2.color <= force_color_enable ? forced_color : pal1;
      q3          <= prod[pcds_pkg::RECIP_SHIFT +: 32];
      sign3       <= sign2;
      side3       <= side2;
      n4          <= {{(pcds_pkg::NW - pcds_pkg::DW){diff[pcds_pkg::DW-1]}}, diff}
                     * pcds_pkg::NW'(pcds_pkg::BANDS);
      side4       <= side3;
    end
  end

endmodule

### hw/rtl/pcds_band.sv
module pcds_band (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v4,
  input  pcds_pkg::side_t         side4,
  input  logic [pcds_pkg::NW-1:0] n4,
  input  logic [30:0]             z_span,
  output logic                    vo,
  output logic                    visible,
  output logic [3:0]              depth_band,
  output logic [7:0]              color
);

  localparam int BW = pcds_pkg::BAND_W;
  localparam int RW = pcds_pkg::NW - 1;

  logic            v    [0:BW];
  pcds_pkg::side_t side [0:BW];
  logic            zero [0:BW];
  logic [RW-1:0]   rem  [0:BW];
  logic [BW-1:0]   quo  [0:BW];
  logic [RW-1:0]   span_e;
  logic [RW-1:0]   limit;

  always_comb begin
    span_e = (z_span == 31'd0) ? RW'(1) : RW'(z_span);
    limit  = span_e * RW'(pcds_pkg::BANDS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= BW; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= v4;
      for (int i = 0; i < BW; i++) begin
        v[i+1] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Negative numerators truncate to a band of zero or below; both clamp to 0.
      side[0] <= side4;
      zero[0] <= n4[pcds_pkg::NW-1] || !side4.vis;
      if (n4[RW-1:0] >= limit) begin
        quo[0] <= BW'(pcds_pkg::BANDS - 1);
        rem[0] <= RW'(0);
      end else begin
        quo[0] <= BW'(0);
        rem[0] <= n4[RW-1:0];
      end
      for (int i = 0; i < BW; i++) begin
        side[i+1] <= side[i];
        zero[i+1] <= zero[i];
        if (rem[i] >= (span_e << (BW - 1 - i))) begin
          rem[i+1] <= rem[i] - (span_e << (BW - 1 - i));
          quo[i+1] <= quo[i] | (BW'(1) << (BW - 1 - i));
        end else begin
          rem[i+1] <= rem[i];
          quo[i+1] <= quo[i];
        end
      end
    end
  end

  assign vo         = v[BW];
  assign visible    = side[BW].vis;
  assign depth_band = zero[BW] ? 4'd0 : 4'(quo[BW]);
  assign color      = side[BW].vis ? side[BW].color : 8'd0;

endmodule

### hw/rtl/polygon_cull_depth_band_shade.sv
// An accepted polygon request runs through the front, mean and band stages to its
// result. Throughput: one request per cycle, palette writes included, while the output is not stalled.
// Reset (synchronous, active high) empties the pipeline and loads the configuration
// defaults; palette contents are left as they are and must be written before use.
module polygon_cull_depth_band_shade (
  input  logic        clk,
  input  logic        rst,
  input  logic        poly_valid,
  output logic        poly_stall,
  input  logic        mode,
  input  logic [31:0] camera_dot,
  input  logic [31:0] plane_distance,
  input  logic [31:0] vertex_z_a,
  input  logic [31:0] vertex_z_b,
  input  logic [31:0] vertex_z_c,
  input  logic [31:0] light_dot,
  input  logic [7:0]  palette_slot,
  input  logic [7:0]  palette_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        visible,
  output logic [3:0]  depth_band,
  output logic [7:0]  color,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The whole pipeline advances together; it only freezes while a finished
  // result sits at the output and the consumer stalls it.
  logic en;
  logic accept;

  logic [31:0] z_minimum;
  logic [30:0] z_span;
  logic        force_color_enable;
  logic [7:0]  forced_color;

  logic            v1, vis1, sign1;
  logic [32:0]     mag1;
  logic [7:0]      pal1;
  logic            v4;
  pcds_pkg::side_t side4;
  logic [pcds_pkg::NW-1:0] n4;

  assign en         = !(result_valid && result_stall);
  assign poly_stall = !en;
  assign accept     = poly_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_minimum          <= 32'd0;
      z_span             <= 31'd1;
      force_color_enable <= 1'b0;
      forced_color       <= 8'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        pcds_pkg::CFG_Z_MINIMUM:    z_minimum          <= cfg_data;
        pcds_pkg::CFG_Z_SPAN:       z_span             <= cfg_data[30:0];
        pcds_pkg::CFG_FORCE_ENABLE: force_color_enable <= cfg_data[0];
        pcds_pkg::CFG_FORCED_COLOR: forced_color       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage 1: visibility test, vertex sum magnitude, palette read.
  pcds_front u_front (
    .clk, .rst, .en, .accept, .mode, .camera_dot, .plane_distance,
    .vertex_z_a, .vertex_z_b, .vertex_z_c, .light_dot, .palette_slot,
    .palette_value, .v1, .vis1, .sign1, .mag1, .pal1
  );

  // Stages 2 to 4: divide by three through a reciprocal, offset and scale; forced color select.
  pcds_mean u_mean (
    .clk, .rst, .en, .v1, .vis1, .sign1, .mag1, .pal1, .z_minimum,
    .force_color_enable, .forced_color, .v4, .side4, .n4
  );

  // Saturation check, then one restoring quotient bit per stage.
  pcds_band u_band (
    .clk, .rst, .en, .v4, .side4, .n4, .z_span, .vo(result_valid),
    .visible, .depth_band, .color
  );

endmodule

### hw/rtl/pcds_checker.sv
module pcds_checker (
  input logic       clk,
  input logic       rst,
  input logic       poly_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic       visible,
  input logic [3:0] depth_band,
  input logic [7:0] color
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(visible)
      && $stable(depth_band) && $stable(color))
    else $error("stalled result changed");

  a_culled_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !visible |-> depth_band == 4'd0 && color == 8'd0)
    else $error("culled polygon carries band or color");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    poly_stall |-> result_valid && result_stall)
    else $error("request stalled without a stalled result");

endmodule

bind polygon_cull_depth_band_shade pcds_checker u_checker (
  .clk, .rst, .poly_stall, .result_valid, .result_stall, .visible, .depth_band, .color
);
